FILE: src/lrrb_pkg.sv
// ----------------------------------------------------------------------------
// lrrb_pkg
// Shared constants for the log record ring buffer: operation codes and the
// fixed widths of the stream fields.
// ----------------------------------------------------------------------------
`default_nettype none

package lrrb_pkg;

    localparam int OP_W    = 2;
    localparam int LEVEL_W = 3;
    localparam int SEQ_W   = 32;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 6;
    localparam int DROP_W  = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 112;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPLAY = 2'd2;

endpackage

`default_nettype wire

FILE: src/lrrb_ring.sv
// ----------------------------------------------------------------------------
// lrrb_ring
// Record store: single write port, single read port, registered read data.
// Read data holds its value until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module lrrb_ring #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 67
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/log_record_ring_buffer_top.sv
// push: taken, then the result is registered from ST_RESP once the output loads
// peek: one store read if in range, result registered once the output loads
// replay: one store read per cycle while the read stage drains, one record per
// cycle while the output flows (filtered records skip it), then a summary
// next input is taken once the previous input's last result is registered
// reset clears head, fill, counters and the level floor; the store is not cleared
`default_nettype none

module log_record_ring_buffer_top
    import lrrb_pkg::*;
#(
    parameter int RING_DEPTH   = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    cfg_wr_en,
    input  wire  [LEVEL_W-1:0]     cfg_wr_data,   // level floor

    input  wire                    s_tvalid,
    output logic                   s_tready,
    // level, payload, age index, filter bypass, zero fill
    input  wire  [S_TDATA_W-1:0]   s_tdata,
    input  wire  [OP_W-1:0]        s_tuser,       // operation

    output logic                   m_tvalid,
    input  wire                    m_tready,
    // ok, seq_no, out_level, out_payload, replay_count, dropped_count, zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tuser,       // is_summary
    output logic                   m_tlast
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MEM_W  = LEVEL_W + SEQ_W + PAYLOAD_BITS;
    localparam int SUM_W  = IDX_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RESP = 3'd1;
    localparam logic [2:0] ST_PEEK = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;

    // input fields
    logic [OP_W-1:0]    in_op;
    logic [LEVEL_W-1:0] in_level;
    logic [DATA_W-1:0]  in_payload;
    logic [IDX_W-1:0]   in_index;
    logic               in_bypass;

    assign in_op      = s_tuser;
    assign in_level   = s_tdata[2:0];
    assign in_payload = s_tdata[34:3];
    assign in_index   = s_tdata[40:35];
    assign in_bypass  = s_tdata[41];

    // control state
    logic [2:0]         state_reg, state_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [DROP_W-1:0]  drop_reg, drop_next;
    logic [LEVEL_W-1:0] level_floor_reg, level_floor_next;
    logic               bypass_reg, bypass_next;
    logic               resp_ok_reg, resp_ok_next;
    logic [SEQ_W-1:0]   resp_seq_reg, resp_seq_next;
    logic [FILL_W-1:0]  walk_reg, walk_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_valid_reg, pend_valid_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               o_ok_reg, o_ok_next;
    logic [SEQ_W-1:0]   o_seq_reg, o_seq_next;
    logic [LEVEL_W-1:0] o_level_reg, o_level_next;
    logic [DATA_W-1:0]  o_pay_reg, o_pay_next;
    logic               o_summary_reg, o_summary_next;
    logic [CNT_W-1:0]   o_count_reg, o_count_next;
    logic [DROP_W-1:0]  o_drop_reg, o_drop_next;
    logic               o_last_reg, o_last_next;

    // store access
    logic               wr_en;
    logic [MEM_W-1:0]   wr_data;
    logic               rd_en;
    logic [HEAD_W-1:0]  rd_addr;
    logic [MEM_W-1:0]   rd_data;
    logic [63:0]        wr_pay_wide;
    logic [63:0]        rd_pay_wide;
    logic [LEVEL_W-1:0] rd_level;
    logic [SEQ_W-1:0]   rd_seq;

    logic               s_fire;
    logic               out_load;
    logic               ring_full;
    logic [HEAD_W-1:0]  oldest;
    logic [IDX_W-1:0]   age;
    logic [SUM_W-1:0]   slot_sum;
    logic               peek_in_range;
    logic               walk_more;
    logic               pend_pass;
    logic               pend_adv;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = !m_valid_reg || m_tready;

    assign ring_full = (fill_reg == FILL_W'(RING_DEPTH));
    assign oldest    = ring_full ? head_reg : '0;

    // logical age to physical slot, sum stays below twice the depth for every age read
    assign age      = (state_reg == ST_IDLE) ? in_index : IDX_W'(walk_reg);
    assign slot_sum = SUM_W'(oldest) + SUM_W'(age);
    assign rd_addr  = (slot_sum >= SUM_W'(RING_DEPTH))
                    ? HEAD_W'(slot_sum - SUM_W'(RING_DEPTH))
                    : HEAD_W'(slot_sum);

    assign peek_in_range = SUM_W'(in_index) < SUM_W'(fill_reg);
    assign walk_more     = walk_reg < fill_reg;

    assign rd_level    = rd_data[MEM_W-1 -: LEVEL_W];
    assign rd_seq      = rd_data[PAYLOAD_BITS +: SEQ_W];
    assign rd_pay_wide = 64'(rd_data[PAYLOAD_BITS-1:0]);

    // a filtered replay record leaves the read stage without using the output
    assign pend_pass = (state_reg == ST_PEEK) || bypass_reg || (rd_level >= level_floor_reg);
    assign pend_adv  = pend_valid_reg && (!pend_pass || out_load);

    assign rd_en = (s_fire && (in_op == OP_PEEK) && peek_in_range)
                || ((state_reg == ST_WALK) && walk_more && (!pend_valid_reg || pend_adv));

    assign wr_en       = s_fire && (in_op == OP_PUSH);
    assign wr_pay_wide = {32'd0, in_payload};
    assign wr_data     = {in_level, seq_reg, wr_pay_wide[PAYLOAD_BITS-1:0]};

    lrrb_ring #(
        .DEPTH (RING_DEPTH),
        .WIDTH (MEM_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (head_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        seq_next         = seq_reg;
        drop_next        = drop_reg;
        level_floor_next = cfg_wr_en ? cfg_wr_data : level_floor_reg;
        bypass_next      = bypass_reg;
        resp_ok_next     = resp_ok_reg;
        resp_seq_next    = resp_seq_reg;
        walk_next        = rd_en && (state_reg == ST_WALK) ? walk_reg + FILL_W'(1) : walk_reg;
        count_next       = count_reg;
        pend_valid_next  = rd_en ? 1'b1 : (pend_adv ? 1'b0 : pend_valid_reg);

        m_valid_next   = m_valid_reg && !m_tready;
        o_ok_next      = o_ok_reg;
        o_seq_next     = o_seq_reg;
        o_level_next   = o_level_reg;
        o_pay_next     = o_pay_reg;
        o_summary_next = o_summary_reg;
        o_count_next   = o_count_reg;
        o_drop_next    = o_drop_reg;
        o_last_next    = o_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_op)
                        OP_PUSH: begin
                            seq_next      = seq_reg + 32'd1;
                            head_next     = (head_reg == HEAD_W'(RING_DEPTH - 1))
                                          ? '0 : head_reg + HEAD_W'(1);
                            if (ring_full) begin
                                drop_next = drop_reg + 32'd1;
                            end else begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            resp_ok_next  = 1'b1;
                            resp_seq_next = seq_reg;
                            state_next    = ST_RESP;
                        end
                        OP_PEEK: begin
                            if (peek_in_range) begin
                                state_next = ST_PEEK;
                            end else begin
                                resp_ok_next  = 1'b0;
                                resp_seq_next = '0;
                                state_next    = ST_RESP;
                            end
                        end
                        OP_REPLAY: begin
                            bypass_next = in_bypass;
                            walk_next   = '0;
                            count_next  = '0;
                            state_next  = ST_WALK;
                        end
                        default: begin
                            resp_ok_next  = 1'b0;
                            resp_seq_next = '0;
                            state_next    = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    m_valid_next   = 1'b1;
                    o_ok_next      = resp_ok_reg;
                    o_seq_next     = resp_seq_reg;
                    o_level_next   = '0;
                    o_pay_next     = '0;
                    o_summary_next = 1'b0;
                    o_count_next   = '0;
                    o_drop_next    = drop_reg;
                    o_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_PEEK, ST_WALK: begin
                if (pend_adv && pend_pass) begin
                    m_valid_next   = 1'b1;
                    o_ok_next      = 1'b1;
                    o_seq_next     = rd_seq;
                    o_level_next   = rd_level;
                    o_pay_next     = rd_pay_wide[DATA_W-1:0];
                    o_summary_next = 1'b0;
                    o_count_next   = '0;
                    o_drop_next    = drop_reg;
                    o_last_next    = (state_reg == ST_PEEK);
                end
                if (state_reg == ST_PEEK) begin
                    if (pend_adv) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    if (pend_adv && pend_pass) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    // walk done once every stored record is read and the read stage drains
                    if (!walk_more && (!pend_valid_reg || pend_adv)) begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (out_load) begin
                    m_valid_next   = 1'b1;
                    o_ok_next      = 1'b1;
                    o_seq_next     = '0;
                    o_level_next   = '0;
                    o_pay_next     = '0;
                    o_summary_next = 1'b1;
                    o_count_next   = count_reg;
                    o_drop_next    = drop_reg;
                    o_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            fill_reg        <= '0;
            seq_reg         <= '0;
            drop_reg        <= '0;
            level_floor_reg <= '0;
            walk_reg        <= '0;
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            fill_reg        <= fill_next;
            seq_reg         <= seq_next;
            drop_reg        <= drop_next;
            level_floor_reg <= level_floor_next;
            walk_reg        <= walk_next;
            count_reg       <= count_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bypass_reg    <= bypass_next;
        resp_ok_reg   <= resp_ok_next;
        resp_seq_reg  <= resp_seq_next;
        o_ok_reg      <= o_ok_next;
        o_seq_reg     <= o_seq_next;
        o_level_reg   <= o_level_next;
        o_pay_reg     <= o_pay_next;
        o_summary_reg <= o_summary_next;
        o_count_reg   <= o_count_next;
        o_drop_reg    <= o_drop_next;
        o_last_reg    <= o_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, o_drop_reg, o_count_reg, o_pay_reg, o_level_reg,
                       o_seq_reg, o_ok_reg};
    assign m_tuser  = o_summary_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_log_record_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_log_record_ring_buffer_top
// Self-checking bench for the log record ring buffer. A directed sequence
// covers the empty ring, an out-of-range peek, the unused opcode and ring
// overflow. Random phases follow, each under its own level floor, mixing
// pushes, peeks, filtered and bypassed replays. A behavioral copy of the ring
// predicts every result transfer, and the output stream is compared in
// order. Random gaps appear on both sides, and long receiver hold-offs let
// the block back up and stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_log_record_ring_buffer_top;
    import lrrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_OPS    = 45;
    localparam int REPORT_LIMIT = 10;

    // opcode with no function, answered with ok=0
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] level;
        logic [DATA_W-1:0]  payload;
        logic [IDX_W-1:0]   age;
        logic               bypass;
    } log_op_t;

    typedef struct packed {
        logic               ok;
        logic [SEQ_W-1:0]   seq;
        logic [LEVEL_W-1:0] level;
        logic [DATA_W-1:0]  payload;
        logic               summary;
        logic [CNT_W-1:0]   count;
        logic [DROP_W-1:0]  dropped;
        logic               last;
    } log_out_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEVEL_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [OP_W-1:0]      s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    log_record_ring_buffer_top #(
        .RING_DEPTH   (DEPTH),
        .PAYLOAD_BITS (DATA_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predicted ring contents
    logic [DATA_W-1:0]  ring_payload [DEPTH];
    logic [LEVEL_W-1:0] ring_level   [DEPTH];
    logic [SEQ_W-1:0]   ring_seq     [DEPTH];
    int unsigned        ring_head       = 0;
    int unsigned        ring_fill       = 0;
    logic [SEQ_W-1:0]   seq_counter     = '0;
    logic [DROP_W-1:0]  dropped_total   = '0;
    logic [LEVEL_W-1:0] level_floor_cur = '0;

    log_op_t  queued_log_ops [$];
    log_out_t expected_log_out [$];

    log_op_t op_on_bus;
    bit      offer_next;
    int      send_gap     = 0;
    int      ready_gap    = 0;
    int      ops_accepted = 0;
    int      hold_left    = 0;
    int      next_hold_at = 80;
    int      cycle_count  = 0;
    int      mismatches   = 0;
    int      gen_fill     = 0;
    bit      steady       = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic log_out_t make_out(logic ok, logic [SEQ_W-1:0] seq,
                                          logic [LEVEL_W-1:0] level,
                                          logic [DATA_W-1:0] payload, logic summary,
                                          logic [CNT_W-1:0] count, logic last);
        log_out_t o;
        o.ok      = ok;
        o.seq     = seq;
        o.level   = level;
        o.payload = payload;
        o.summary = summary;
        o.count   = count;
        o.dropped = dropped_total;
        o.last    = last;
        return o;
    endfunction

    function automatic int unsigned slot_of_age(int unsigned age);
        return (((ring_fill < DEPTH) ? 0 : ring_head) + age) % DEPTH;
    endfunction

    // updates the ring copy and queues the result transfers for one input
    function automatic void apply_log_op(log_op_t item);
        int unsigned slot;
        int          emitted;
        case (item.op)
            OP_PUSH: begin
                ring_payload[SLOT_W'(ring_head)] = item.payload;
                ring_level[SLOT_W'(ring_head)]   = item.level;
                ring_seq[SLOT_W'(ring_head)]     = seq_counter;
                ring_head = (ring_head + 1) % DEPTH;
                if (ring_fill < DEPTH) ring_fill++;
                else dropped_total = dropped_total + 32'd1;
                expected_log_out.push_back(make_out(1'b1, seq_counter, '0, '0, 1'b0, '0,
                                                    1'b1));
                seq_counter = seq_counter + 32'd1;
            end
            OP_PEEK: begin
                if (item.age >= ring_fill) begin
                    expected_log_out.push_back(make_out(1'b0, '0, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    slot = slot_of_age(item.age);
                    expected_log_out.push_back(make_out(1'b1, ring_seq[SLOT_W'(slot)],
                                                        ring_level[SLOT_W'(slot)],
                                                        ring_payload[SLOT_W'(slot)], 1'b0,
                                                        '0, 1'b1));
                end
            end
            OP_REPLAY: begin
                emitted = 0;
                for (int unsigned i = 0; i < ring_fill; i++) begin
                    slot = slot_of_age(i);
                    if (item.bypass || ring_level[SLOT_W'(slot)] >= level_floor_cur) begin
                        expected_log_out.push_back(make_out(1'b1, ring_seq[SLOT_W'(slot)],
                                                            ring_level[SLOT_W'(slot)],
                                                            ring_payload[SLOT_W'(slot)],
                                                            1'b0, '0, 1'b0));
                        emitted++;
                    end
                end
                expected_log_out.push_back(make_out(1'b1, '0, '0, '0, 1'b1,
                                                    CNT_W'(emitted), 1'b1));
            end
            default: begin
                expected_log_out.push_back(make_out(1'b0, '0, '0, '0, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            offer_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_log_op(op_on_bus);
                ops_accepted <= ops_accepted + 1;
                offer_next = 1'b0;
            end
            if (!offer_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_log_ops.size() > 0) begin
                    op_on_bus = queued_log_ops.pop_front();
                    s_tdata <= {6'b0, op_on_bus.bypass, op_on_bus.age, op_on_bus.payload,
                                op_on_bus.level};
                    s_tuser <= op_on_bus.op;
                    offer_next = 1'b1;
                    send_gap = pick_gap();
                end
            end
            s_tvalid <= offer_next;
        end
    end

    // long receiver hold-off every so many accepted inputs
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (ops_accepted >= next_hold_at) begin
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 90;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        log_out_t got;
        log_out_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.ok      = m_tdata[0];
                got.seq     = m_tdata[32:1];
                got.level   = m_tdata[35:33];
                got.payload = m_tdata[67:36];
                got.count   = m_tdata[73:68];
                got.dropped = m_tdata[105:74];
                got.summary = m_tuser;
                got.last    = m_tlast;
                if (expected_log_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result transfer at cycle %0d", cycle_count);
                end else begin
                    want = expected_log_out.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  exp ok=%0b seq=%0d lvl=%0d", want.ok, want.seq,
                                     want.level, " pay=%08h sum=%0b", want.payload,
                                     want.summary, " cnt=%0d drop=%0d last=%0b",
                                     want.count, want.dropped, want.last);
                            $display("  got ok=%0b seq=%0d lvl=%0d", got.ok, got.seq,
                                     got.level, " pay=%08h sum=%0b", got.payload,
                                     got.summary, " cnt=%0d drop=%0d last=%0b",
                                     got.count, got.dropped, got.last);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                ready_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("log_record_ring_buffer_top regression: fail");
            $finish;
        end
    end

    task automatic queue_op(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] level,
                            logic [DATA_W-1:0] payload, logic [IDX_W-1:0] age, logic bypass);
        log_op_t item;
        item.op      = op;
        item.level   = level;
        item.payload = payload;
        item.age     = age;
        item.bypass  = bypass;
        if (op == OP_PUSH && gen_fill < DEPTH) gen_fill++;
        queued_log_ops.push_back(item);
    endtask

    task automatic queue_random_ops(int count);
        int                r;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  age;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) op = OP_PUSH;
            else if (r < 75) op = OP_PEEK;
            else if (r < 94) op = OP_REPLAY;
            else op = OP_UNUSED;
            // peeks mostly land on stored records, the rest anywhere
            if (gen_fill > 0 && $urandom_range(0, 3) != 0)
                age = IDX_W'($urandom_range(0, gen_fill - 1));
            else
                age = IDX_W'($urandom_range(0, 63));
            queue_op(op, LEVEL_W'($urandom_range(0, 7)), $urandom, age,
                     1'($urandom_range(0, 1)));
        end
    endtask

    // sampled mid-cycle so that the driver's updates at the edge are settled
    task automatic wait_idle();
        while (queued_log_ops.size() > 0 || s_tvalid || expected_log_out.size() > 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_level_floor(logic [LEVEL_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        level_floor_cur = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_level_floor(3'd0);
        // empty ring: peek, replay, then the unused opcode
        queue_op(OP_PEEK, 3'd0, 32'h0, 6'd0, 1'b0);
        queue_op(OP_REPLAY, 3'd0, 32'h0, 6'd0, 1'b0);
        queue_op(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1);
        queue_op(OP_PUSH, 3'd0, 32'h0000_0000, 6'd0, 1'b0);
        queue_op(OP_PUSH, 3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1);
        queue_op(OP_PEEK, 3'd0, 32'h0, 6'd0, 1'b0);
        queue_op(OP_PEEK, 3'd0, 32'h0, 6'd2, 1'b0);
        queue_op(OP_PEEK, 3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1);
        queue_op(OP_REPLAY, 3'd0, 32'h0, 6'd0, 1'b0);
        // fill the ring and overwrite the oldest record once
        for (int i = 0; i < 15; i++)
            queue_op(OP_PUSH, LEVEL_W'($urandom_range(0, 7)), $urandom, 6'd0, 1'b0);
        queue_op(OP_PEEK, 3'd0, 32'h0, 6'd15, 1'b0);
        queue_op(OP_REPLAY, 3'd0, 32'h0, 6'd0, 1'b1);
        wait_idle();

        write_level_floor(3'd7);
        queue_random_ops(PHASE_OPS);
        wait_idle();

        write_level_floor(LEVEL_W'($urandom_range(1, 6)));
        steady = 1'b1;
        queue_random_ops(PHASE_OPS);
        wait_idle();
        steady = 1'b0;

        write_level_floor(3'd0);
        queue_random_ops(PHASE_OPS);
        wait_idle();

        write_level_floor(LEVEL_W'($urandom_range(0, 7)));
        queue_random_ops(PHASE_OPS);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_log_out.size() == 0) begin
            $display("log_record_ring_buffer_top regression: pass");
        end else begin
            $display("log_record_ring_buffer_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/lrrb_pkg.sv
src/lrrb_ring.sv
src/log_record_ring_buffer_top.sv
tb/sv/tb_log_record_ring_buffer_top.sv
